// ----- rtl/nhts_pkg.sv -----
`default_nettype none
package nhts_pkg;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  node_address;
    logic [7:0]  proto_major;
    logic [2:0]  state_bits;
    logic [7:0]  node_error_code;
    logic [31:0] task_ref;
    logic [3:0]  new_status;
    logic [31:0] timeout_ms;
    logic        router_accepted;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic        node_found;
    logic [31:0] task_id_out;
    logic [3:0]  task_status;
    logic        node_online;
    logic        node_ready;
    logic        node_busy;
    logic        node_error;
    logic        node_incompatible;
    logic [7:0]  last_error_code;
    logic        all_required_ready;
  } out_item_t;

  localparam logic [2:0] MODE_HB    = 3'd0;
  localparam logic [2:0] MODE_STAT  = 3'd1;
  localparam logic [2:0] MODE_TICK  = 3'd2;
  localparam logic [2:0] MODE_ISSUE = 3'd3;
  localparam logic [2:0] MODE_QUERY = 3'd4;

  localparam logic [3:0] ST_UNKNOWN  = 4'd0;
  localparam logic [3:0] ST_QUEUED   = 4'd1;
  localparam logic [3:0] ST_SENT     = 4'd2;
  localparam logic [3:0] ST_ACCEPTED = 4'd3;
  localparam logic [3:0] ST_RUNNING  = 4'd4;
  localparam logic [3:0] ST_DONE     = 4'd5;
  localparam logic [3:0] ST_FAILED   = 4'd6;
  localparam logic [3:0] ST_TIMEOUT  = 4'd7;
  localparam logic [3:0] ST_REJECTED = 4'd8;

  localparam logic [2:0] CFG_ADDRS   = 3'd0;
  localparam logic [2:0] CFG_MAJORS  = 3'd1;
  localparam logic [2:0] CFG_REQ     = 3'd2;
  localparam logic [2:0] CFG_COUNT   = 3'd3;
  localparam logic [2:0] CFG_HB_TMO  = 3'd4;
  localparam logic [2:0] CFG_TSK_TMO = 3'd5;

  // token passed along the row of node cells
  typedef struct packed {
    logic        act;
    logic        found;
    logic [31:0] issued;
    logic [3:0]  status;
    logic [4:0]  flags;
    logic [7:0]  ecode;
  } tok_t;

  // per-node results seen by the top level
  typedef struct packed {
    logic [4:0]  flags;
  } cell_stat_t;

  function automatic logic in_flight(input logic [3:0] s);
    return (s == ST_SENT) || (s == ST_ACCEPTED) || (s == ST_RUNNING);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/nhts_cell.sv -----
`default_nettype none
module nhts_cell (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_use,
  input  wire logic [7:0]       addr,
  input  wire logic [7:0]       major,
  input  wire logic [31:0]      hb_tmo,
  input  wire logic [31:0]      dflt_tmo,
  input  wire nhts_pkg::in_item_t item,
  input  wire logic [31:0]      id_in,
  input  wire nhts_pkg::tok_t   tok_in,
  output nhts_pkg::tok_t        tok_out,
  output logic                  id_used,
  output nhts_pkg::cell_stat_t  stat
);
  import nhts_pkg::*;

  logic [31:0] heard_r, task_r, dl_r;
  logic [4:0]  flags_r;
  logic [7:0]  ecode_r;
  logic [3:0]  st_r;
  logic [31:0] heard_nxt, task_nxt, dl_nxt;
  logic [4:0]  flags_nxt, f;
  logic [7:0]  ecode_nxt;
  logic [3:0]  st_nxt;
  logic        hit;
  logic [31:0] tmo;

  assign stat.flags   = flags_r;

  always_comb begin
    heard_nxt = heard_r; task_nxt = task_r; dl_nxt = dl_r;
    flags_nxt = flags_r; ecode_nxt = ecode_r; st_nxt = st_r;
    tok_out = tok_in;
    id_used = 1'b0;
    hit = 1'b0;
    f = 5'd0;
    tmo = (item.timeout_ms == 32'd0) ? dflt_tmo : item.timeout_ms;
    case (item.mode)
      MODE_HB, MODE_ISSUE: hit = (addr == item.node_address);
      MODE_STAT, MODE_QUERY: hit = (task_r == item.task_ref);
      default: hit = 1'b0;
    endcase
    hit = hit && in_use && tok_in.act && !tok_in.found;
    if (en && in_use && item.mode == MODE_TICK) begin
      if (heard_r != 32'd0 && (item.now_ms - heard_r) > hb_tmo) begin
        flags_nxt = flags_r & 5'b11000;
        if (in_flight(st_r)) begin
          st_nxt = ST_TIMEOUT; dl_nxt = 32'd0;
        end
      end
      if (dl_nxt != 32'd0 && item.now_ms > dl_nxt &&
          (st_nxt == ST_QUEUED || in_flight(st_nxt))) begin
        st_nxt = ST_TIMEOUT; dl_nxt = 32'd0;
      end
    end else if (en && hit) begin
      case (item.mode)
        MODE_HB: begin
          f = {1'b0, item.state_bits, 1'b1};
          if (item.proto_major != major) f = (f | 5'b10000) & 5'b11110;
          heard_nxt = item.now_ms;
          flags_nxt = f;
          ecode_nxt = item.node_error_code;
          if (item.task_ref != 32'd0) begin
            if (task_r == 32'd0 || task_r[15:0] == item.task_ref[15:0]) begin
              if (task_r == 32'd0) task_nxt = item.task_ref;
              st_nxt = f[2] ? ST_RUNNING : ST_ACCEPTED;
            end
          end else if (in_flight(st_r)) begin
            st_nxt = f[3] ? ST_FAILED : ST_DONE;
            dl_nxt = 32'd0;
          end
        end
        MODE_STAT: begin
          if (item.new_status <= ST_REJECTED) begin
            st_nxt = item.new_status;
            if (item.new_status >= ST_DONE) dl_nxt = 32'd0;
          end
        end
        MODE_ISSUE: begin
          id_used = 1'b1;
          task_nxt = id_in;
          if (flags_r[4]) begin
            st_nxt = ST_REJECTED; dl_nxt = 32'd0;
          end else begin
            st_nxt = item.router_accepted ? ST_QUEUED : ST_REJECTED;
            dl_nxt = item.now_ms + tmo;
          end
        end
        default: ;
      endcase
      tok_out.found  = 1'b1;
      tok_out.issued = (item.mode == MODE_ISSUE) ? id_in : 32'd0;
      tok_out.status = st_nxt;
      tok_out.flags  = flags_nxt;
      tok_out.ecode  = ecode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heard_r <= '0; task_r <= '0; dl_r <= '0;
      flags_r <= '0; ecode_r <= '0; st_r <= ST_UNKNOWN;
    end else begin
      heard_r <= heard_nxt; task_r <= task_nxt; dl_r <= dl_nxt;
      flags_r <= flags_nxt; ecode_r <= ecode_nxt; st_r <= st_nxt;
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(task_r) && $stable(st_r) && $stable(flags_r))
    else $error("cell state changed while not selected");
  a_issue_zero: assert property (@(posedge clk) disable iff (!rst_n)
    id_used |-> id_in != 32'd0) else $error("zero task id issued");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    tok_in.found |-> !id_used) else $error("second cell took the id");
`endif
endmodule
`default_nettype wire

// ----- rtl/node_heartbeat_task_supervisor.sv -----
// node heartbeat and task supervisor: a row of node cells visited one per cycle
// the walk ends in done_r, registered into out_valid; busy stays high during the walk
// a new item is taken only while busy is low, so one item walks the cell row at a time
// the receiver cannot stall: each result shows for exactly one cycle
// reset (synchronous, rst_n low) clears node state, next id to 1, config defaults
`default_nettype none
module node_heartbeat_task_supervisor #(
  parameter int NODES = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire nhts_pkg::in_item_t  in_item,
  output logic                     out_valid,
  output nhts_pkg::out_item_t      out_item,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [63:0]         cfg_wdata
);
  import nhts_pkg::*;

  localparam int CW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int NW = $clog2(NODES + 1);

  // configuration
  logic [63:0] addrs_r, majors_r;
  logic [7:0]  req_r;
  logic [3:0]  count_r;
  logic [31:0] hb_tmo_r, tsk_tmo_r;

  logic [31:0] next_id_r, id_cur;
  in_item_t    item_r;
  logic [CW-1:0] pos_r;
  tok_t        tok_r;
  logic        run_r;

  tok_t        toks [NODES];
  logic [NODES-1:0] used;
  cell_stat_t  stats [NODES];
  logic [NODES-1:0] en;
  logic [NW-1:0] n_use;
  logic        all_rdy;

  assign n_use = (count_r > 4'(NODES)) ? NW'(NODES) : NW'(count_r);
  assign busy  = run_r;
  assign id_cur = (next_id_r == 32'd0) ? 32'd1 : next_id_r;

  // one cell works per cycle; the token carries the lookup result down the row
  for (genvar k = 0; k < NODES; k++) begin : g_cell
    assign en[k] = run_r && (pos_r == CW'(k));
    nhts_cell u_cell (
      .clk, .rst_n,
      .en(en[k]),
      .in_use(NW'(k) < n_use),
      .addr(addrs_r[8*k +: 8]),
      .major(majors_r[8*k +: 8]),
      .hb_tmo(hb_tmo_r),
      .dflt_tmo(tsk_tmo_r),
      .item(item_r),
      .id_in(id_cur),
      .tok_in(tok_r),
      .tok_out(toks[k]),
      .id_used(used[k]),
      .stat(stats[k])
    );
  end

  // required-ready check over the state as it stands when results are shown
  always_comb begin
    all_rdy = 1'b1;
    for (int k = 0; k < NODES; k++) begin
      if (NW'(k) < n_use && req_r[k] &&
          !(stats[k].flags[0] && stats[k].flags[1] &&
            !stats[k].flags[3] && !stats[k].flags[4]))
        all_rdy = 1'b0;
    end
  end

  logic done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addrs_r <= '0; majors_r <= 64'h0101010101010101; req_r <= '0;
      count_r <= '0; hb_tmo_r <= 32'd1000; tsk_tmo_r <= 32'd5000;
      next_id_r <= 32'd1; run_r <= 1'b0; done_r <= 1'b0; pos_r <= '0;
      out_valid <= 1'b0; tok_r <= '0;
    end else begin
      // result shows once done_r, set at the end of the walk, is registered into out_valid
      out_valid <= done_r;
      done_r    <= run_r && (pos_r == CW'(NODES - 1));
      if (cfg_we) begin
        case (cfg_index)
          CFG_ADDRS:   addrs_r   <= cfg_wdata;
          CFG_MAJORS:  majors_r  <= cfg_wdata;
          CFG_REQ:     req_r     <= cfg_wdata[7:0];
          CFG_COUNT:   count_r   <= cfg_wdata[3:0];
          CFG_HB_TMO:  hb_tmo_r  <= cfg_wdata[31:0];
          CFG_TSK_TMO: tsk_tmo_r <= cfg_wdata[31:0];
          default: ;
        endcase
      end
      // a new item may enter while the previous result is being captured
      if (start && !run_r) begin
        item_r <= in_item;
        run_r  <= 1'b1;
        pos_r  <= '0;
        tok_r  <= '{act: 1'b1, default: '0};
      end else if (run_r) begin
        tok_r <= toks[pos_r];
        if (|used) next_id_r <= id_cur + 32'd1;
        if (pos_r == CW'(NODES - 1)) begin
          run_r  <= 1'b0;
        end else begin
          pos_r <= pos_r + CW'(1);
        end
      end
    end
  end

  // result registered while done_r is high, after the walk, so all_ready sees final state
  always_ff @(posedge clk) begin
    if (done_r) begin
      out_item.node_found         <= tok_r.found;
      out_item.task_id_out        <= tok_r.issued;
      out_item.task_status        <= tok_r.status;
      out_item.node_online        <= tok_r.flags[0];
      out_item.node_ready         <= tok_r.flags[1];
      out_item.node_busy          <= tok_r.flags[2];
      out_item.node_error         <= tok_r.flags[3];
      out_item.node_incompatible  <= tok_r.flags[4];
      out_item.last_error_code    <= tok_r.ecode;
      out_item.all_required_ready <= all_rdy;
    end
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(en)) else $error("more than one cell enabled");
  a_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !done_r) else $error("result overlaps the end of a walk");
  a_used: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(used)) else $error("id taken twice");
`endif
endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
`default_nettype none

// scoreboard: keeps a mirror of the supervisor state and the queue of
// expected results, one per accepted item
class supervisor_board;
  bit [63:0] addrs;
  bit [63:0] majors;
  bit [7:0]  req_mask;
  bit [3:0]  count;
  bit [31:0] hb_tmo;
  bit [31:0] task_tmo;
  bit [31:0] heard [8];
  bit [4:0]  flags [8];
  bit [7:0]  ecode [8];
  bit [31:0] task_id [8];
  bit [3:0]  status [8];
  bit [31:0] due [8];
  bit [31:0] next_id;
  nhts_pkg::out_item_t pending [$];
  int errors;

  localparam bit [4:0] F_ON = 5'h01, F_RDY = 5'h02, F_BSY = 5'h04,
                       F_ERR = 5'h08, F_INC = 5'h10;

  function void clear();
    addrs = '0; majors = 64'h0101010101010101; req_mask = '0; count = '0;
    hb_tmo = 1000; task_tmo = 5000; next_id = 1;
    for (int k = 0; k < 8; k++) begin
      heard[k] = 0; flags[k] = 0; ecode[k] = 0;
      task_id[k] = 0; status[k] = 0; due[k] = 0;
    end
    pending.delete();
    errors = 0;
  endfunction

  function void write_reg(bit [2:0] idx, bit [63:0] v);
    case (idx)
      nhts_pkg::CFG_ADDRS:   addrs = v;
      nhts_pkg::CFG_MAJORS:  majors = v;
      nhts_pkg::CFG_REQ:     req_mask = v[7:0];
      nhts_pkg::CFG_COUNT:   count = v[3:0];
      nhts_pkg::CFG_HB_TMO:  hb_tmo = v[31:0];
      nhts_pkg::CFG_TSK_TMO: task_tmo = v[31:0];
      default: ;
    endcase
  endfunction

  function int used();
    return (count > 8) ? 8 : count;
  endfunction

  function bit flying(bit [3:0] s);
    return s == nhts_pkg::ST_SENT || s == nhts_pkg::ST_ACCEPTED ||
           s == nhts_pkg::ST_RUNNING;
  endfunction

  function int by_addr(bit [7:0] a);
    for (int k = 0; k < used(); k++) if (addrs[8*k +: 8] == a) return k;
    return -1;
  endfunction

  function int by_task(bit [31:0] id);
    for (int k = 0; k < used(); k++) if (task_id[k] == id) return k;
    return -1;
  endfunction

  // work out the state change and the result of one accepted item
  function void note_item(nhts_pkg::in_item_t it);
    int k;
    bit [31:0] issued;
    bit [4:0] f;
    bit rdy;
    nhts_pkg::out_item_t r;
    k = -1; issued = 0;
    case (it.mode)
      nhts_pkg::MODE_HB: begin
        k = by_addr(it.node_address);
        if (k >= 0) begin
          f = F_ON;
          if (it.state_bits[0]) f |= F_RDY;
          if (it.state_bits[1]) f |= F_BSY;
          if (it.state_bits[2]) f |= F_ERR;
          if (it.proto_major != majors[8*k +: 8]) f = (f | F_INC) & ~F_ON;
          heard[k] = it.now_ms; flags[k] = f; ecode[k] = it.node_error_code;
          if (it.task_ref != 0) begin
            if (task_id[k] == 0 || task_id[k][15:0] == it.task_ref[15:0]) begin
              if (task_id[k] == 0) task_id[k] = it.task_ref;
              status[k] = (f & F_BSY) ? nhts_pkg::ST_RUNNING : nhts_pkg::ST_ACCEPTED;
            end
          end else if (flying(status[k])) begin
            status[k] = (f & F_ERR) ? nhts_pkg::ST_FAILED : nhts_pkg::ST_DONE;
            due[k] = 0;
          end
        end
      end
      nhts_pkg::MODE_STAT: begin
        k = by_task(it.task_ref);
        if (k >= 0 && it.new_status <= nhts_pkg::ST_REJECTED) begin
          status[k] = it.new_status;
          if (it.new_status >= nhts_pkg::ST_DONE) due[k] = 0;
        end
      end
      nhts_pkg::MODE_TICK: begin
        for (int j = 0; j < used(); j++) begin
          if (heard[j] != 0 && (it.now_ms - heard[j]) > hb_tmo) begin
            flags[j] &= ~(F_ON | F_RDY | F_BSY);
            if (flying(status[j])) begin
              status[j] = nhts_pkg::ST_TIMEOUT; due[j] = 0;
            end
          end
          if (due[j] != 0 && it.now_ms > due[j] &&
              (status[j] == nhts_pkg::ST_QUEUED || flying(status[j]))) begin
            status[j] = nhts_pkg::ST_TIMEOUT; due[j] = 0;
          end
        end
      end
      nhts_pkg::MODE_ISSUE: begin
        k = by_addr(it.node_address);
        if (k >= 0) begin
          if (next_id == 0) next_id = 1;
          issued = next_id; next_id++;
          task_id[k] = issued;
          if (flags[k] & F_INC) begin
            status[k] = nhts_pkg::ST_REJECTED; due[k] = 0;
          end else begin
            due[k] = it.now_ms + ((it.timeout_ms == 0) ? task_tmo : it.timeout_ms);
            status[k] = it.router_accepted ? nhts_pkg::ST_QUEUED : nhts_pkg::ST_REJECTED;
          end
        end
      end
      nhts_pkg::MODE_QUERY: k = by_task(it.task_ref);
      default: ;
    endcase
    r = '0;
    if (k >= 0) begin
      r.node_found = 1; r.task_id_out = issued; r.task_status = status[k];
      r.node_online = flags[k][0]; r.node_ready = flags[k][1];
      r.node_busy = flags[k][2]; r.node_error = flags[k][3];
      r.node_incompatible = flags[k][4]; r.last_error_code = ecode[k];
    end
    rdy = 1;
    for (int j = 0; j < used(); j++)
      if (req_mask[j] && (!flags[j][0] || !flags[j][1] || flags[j][3] || flags[j][4]))
        rdy = 0;
    r.all_required_ready = rdy;
    pending.push_back(r);
  endfunction

  function void check_result(nhts_pkg::out_item_t got);
    nhts_pkg::out_item_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      $display("%0t: mismatch expected %h actual %h", $time, want, got);
      $display("  found %0d/%0d id %0h/%0h status %0d/%0d flags %b/%b ecode %0h/%0h rdy %0d/%0d",
               want.node_found, got.node_found, want.task_id_out, got.task_id_out,
               want.task_status, got.task_status,
               {want.node_incompatible, want.node_error, want.node_busy, want.node_ready,
                want.node_online},
               {got.node_incompatible, got.node_error, got.node_busy, got.node_ready,
                got.node_online},
               want.last_error_code, got.last_error_code,
               want.all_required_ready, got.all_required_ready);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import nhts_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  supervisor_board board = new();
  int          send_idle;    // percent of cycles the sender holds off
  bit [31:0]   clock_ms;     // running time, mostly climbing
  bit [31:0]   recent_ids [$];

  node_heartbeat_task_supervisor dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // results are sampled at the edge that ends their cycle
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_result(out_item);
  end

  // hard limit: ~1750 items plus idling fits well inside this
  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // register write, only while idle
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    board.write_reg(idx, v);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // offer one item; it is accepted at the edge where start is high and busy low
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    start <= 1; in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_item(it);
    start <= 0;
    if (it.mode == MODE_ISSUE && board.pending[$].node_found)
      recent_ids.push_back(board.pending[$].task_id_out);
    if (recent_ids.size() > 16) void'(recent_ids.pop_front());
    @(posedge clk);
  endtask

  // wait for every expected result, then a margin for the latency
  task automatic drain();
    int guard;
    guard = 0;
    while (board.pending.size() != 0 && guard < 1000) begin
      @(posedge clk); guard++;
    end
    repeat (12) @(posedge clk);
  endtask

  // random item biased toward configured addresses and live task ids
  function automatic in_item_t rand_item();
    in_item_t it;
    int n, r;
    it = '0;
    r = $urandom_range(99);
    it.mode = (r < 30) ? MODE_HB : (r < 45) ? MODE_STAT : (r < 60) ? MODE_TICK :
              (r < 78) ? MODE_ISSUE : (r < 95) ? MODE_QUERY : 3'($urandom_range(7));
    n = board.used();
    if (n > 0 && $urandom_range(9) < 8)
      it.node_address = board.addrs[8*$urandom_range(n-1) +: 8];
    else
      it.node_address = 8'($urandom);
    it.proto_major = ($urandom_range(9) < 8 && n > 0) ?
      board.majors[8*$urandom_range(n-1) +: 8] : 8'($urandom);
    it.state_bits = 3'($urandom);
    it.node_error_code = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00;
    r = $urandom_range(9);
    if (r < 5 && recent_ids.size() > 0)
      it.task_ref = recent_ids[$urandom_range(recent_ids.size()-1)];
    else if (r < 7) it.task_ref = 0;
    else if (r < 8 && recent_ids.size() > 0)
      it.task_ref = {16'($urandom), recent_ids[$][15:0]};
    else it.task_ref = $urandom;
    it.new_status = 4'($urandom_range(15));
    r = $urandom_range(9);
    it.timeout_ms = (r < 3) ? 0 : (r < 8) ? $urandom_range(3000) : $urandom;
    it.router_accepted = $urandom_range(9) != 0;
    r = $urandom_range(19);
    if (r == 0) clock_ms = $urandom;
    else if (r == 1) clock_ms = 0;
    else clock_ms += $urandom_range(1500);
    it.now_ms = clock_ms;
    return it;
  endfunction

  function automatic in_item_t mk(input logic [2:0] md, input logic [7:0] a,
                                  input logic [7:0] maj, input logic [2:0] sb,
                                  input logic [31:0] tr, input logic [31:0] now);
    in_item_t it;
    it = '0;
    it.mode = md; it.node_address = a; it.proto_major = maj;
    it.state_bits = sb; it.task_ref = tr; it.now_ms = now;
    it.router_accepted = 1;
    return it;
  endfunction

  initial begin
    in_item_t it;
    board.clear();
    send_idle = 0;
    clock_ms = 100;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: lookups with an empty table all read as no match
    send_item(mk(MODE_HB, 8'h00, 8'h01, 3'd1, 0, 10));
    send_item(mk(MODE_QUERY, 8'h00, 8'h00, 3'd0, 0, 10));
    drain();

    // full table with all-ones extremes, duplicate address on entry 7
    write_reg(CFG_ADDRS, 64'h10FF_2010_0807_0201);
    write_reg(CFG_MAJORS, 64'hFF00_0101_0101_0201);
    write_reg(CFG_REQ, 64'hFF);
    write_reg(CFG_COUNT, 64'd15);   // above NODES acts as NODES
    write_reg(CFG_HB_TMO, 64'd500);
    write_reg(CFG_TSK_TMO, 64'd2000);

    send_item(mk(MODE_HB, 8'h01, 8'h01, 3'd1, 0, 0));          // heartbeat at time zero
    send_item(mk(MODE_HB, 8'h02, 8'h02, 3'd7, 32'hFFFF_FFFF, 1000)); // all bits set
    send_item(mk(MODE_HB, 8'h07, 8'h09, 3'd1, 0, 1000));       // major mismatch
    it = mk(MODE_ISSUE, 8'h07, 0, 0, 0, 1000);                 // issue to incompatible
    send_item(it);
    it = mk(MODE_ISSUE, 8'h01, 0, 0, 0, 1000);                 // default timeout
    send_item(it);
    it.node_address = 8'h08; it.router_accepted = 0;           // router rejection
    send_item(it);
    it = mk(MODE_ISSUE, 8'h10, 0, 0, 0, 32'hFFFF_FF00);
    it.timeout_ms = 32'h100;                                   // deadline wraps to zero
    send_item(it);
    send_item(mk(MODE_HB, 8'h01, 8'h01, 3'd3, 32'hABCD_0002, 1100)); // low-16 match
    send_item(mk(MODE_HB, 8'h01, 8'h01, 3'd1, 0, 1200));       // in flight to done
    send_item(mk(MODE_HB, 8'h02, 8'h02, 3'd5, 0, 1200));       // in flight to failed
    it = mk(MODE_STAT, 0, 0, 0, 32'd1, 1200); it.new_status = 4'd15; // code above 8
    send_item(it);
    it.new_status = ST_RUNNING; send_item(it);
    it = mk(MODE_STAT, 0, 0, 0, 0, 1200); it.new_status = ST_SENT;   // id 0: empty node
    send_item(it);
    send_item(mk(MODE_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send_item(mk(MODE_QUERY, 0, 0, 0, 32'd1, 0));
    send_item(mk(3'd5, 8'h01, 0, 0, 0, 0));
    send_item(mk(3'd7, 8'h01, 0, 0, 0, 0));
    send_item(mk(MODE_HB, 8'hFF, 8'hFF, 3'd0, 0, 5));
    drain();

    // random phases, each with its own table and idling; the drain before
    // each reconfiguration is also the sender pausing until all results came
    for (int ph = 0; ph < 7; ph++) begin
      case (ph % 4)
        0: send_idle = 0;
        1: send_idle = 67;
        2: send_idle = 0;
        default: send_idle = 34;
      endcase
      if (ph == 6) begin
        write_reg(CFG_ADDRS, 64'h0);
        write_reg(CFG_MAJORS, 64'h0);
        write_reg(CFG_REQ, 64'h0);
        write_reg(CFG_COUNT, 64'd1);
        write_reg(CFG_HB_TMO, 64'hFFFF_FFFF);
        write_reg(CFG_TSK_TMO, 64'd0);
      end else begin
        write_reg(CFG_ADDRS, {$urandom, $urandom} & 64'h0F0F_0F0F_0F0F_0F0F);
        write_reg(CFG_MAJORS, ($urandom_range(1)) ? 64'h0101_0101_0101_0101 :
                              {$urandom, $urandom} & 64'h0303_0303_0303_0303);
        write_reg(CFG_REQ, 64'($urandom_range(255)));
        write_reg(CFG_COUNT, 64'($urandom_range(8, 1)));
        write_reg(CFG_HB_TMO, (ph == 3) ? 64'd0 : 64'($urandom_range(2000)));
        write_reg(CFG_TSK_TMO, 64'($urandom_range(6000)));
      end
      for (int i = 0; i < 250; i++) send_item(rand_item());
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/nhts_pkg.sv
rtl/nhts_cell.sv
rtl/node_heartbeat_task_supervisor.sv
test/tb_top.sv
